/* rtl/dpt_pkg.sv */
// shared types for the demand paged translation unit
package dpt_pkg;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } dpt_state_e;

  // per-transaction result flags
  typedef struct packed {
    logic out_of_pages;
    logic newly_mapped;
    logic tlb_hit;
  } dpt_flags_t;

  localparam int unsigned VA_BITS   = 22;
  localparam int unsigned PA_BITS   = 20;
  localparam int unsigned CNT_BITS  = 32;
  localparam int unsigned IN_BYTES  = (VA_BITS + 7) / 8;
  localparam int unsigned OUT_FIELD = PA_BITS + 2 * CNT_BITS;
  localparam int unsigned OUT_BYTES = (OUT_FIELD + 7) / 8;

endpackage

/* rtl/demand_paged_translation_unit.sv */
// top level: demand paged address translation with a direct-mapped tlb
//
// One virtual address enters per slave transaction on s_axis (tdata bits 21:0).
// Each produces exactly one master transaction on m_axis carrying the physical
// address, the two running counters, and in tuser the hit, newly-mapped and
// out-of-pages flags.
// For each item, the accept cycle in the idle state issues reads of the tlb
// memory and the page table memory together; the lookup state then compares
// the tag, picks or allocates the page, refills the tlb on a miss unless out
// of pages and the page table on a new mapping, and loads the output register.
// s_axis_tready is low in the lookup state, so the next item is accepted only
// after that lookup completes. Writes finish before the next read is issued,
// so no forwarding is needed. After reset the page table is swept clear, one
// entry a cycle, over all 2^(UPPER_INDEX_BITS+LOWER_INDEX_BITS) entries
// (1024 by default); s_axis_tready stays low during the sweep. When m_axis
// stalls, one result waits in the output register while the next item is still
// accepted; that item then holds in the lookup state until the register frees up.
module demand_paged_translation_unit #(
  parameter int unsigned OFFSET_BITS      = 12,
  parameter int unsigned UPPER_INDEX_BITS = 5,
  parameter int unsigned LOWER_INDEX_BITS = 5,
  parameter int unsigned TLB_INDEX_BITS   = 4,
  parameter int unsigned PHYS_PAGES       = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // virt_addr [21:0], zero fill [23:22]
  input  logic [8*dpt_pkg::IN_BYTES-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // phys_addr [19:0], hit_total [51:20], query_total [83:52], zero fill [87:84]
  output logic [8*dpt_pkg::OUT_BYTES-1:0]     m_axis_tdata,
  // tlb_hit [0], newly_mapped [1], out_of_pages [2]
  output logic [2:0]                          m_axis_tuser
);
  import dpt_pkg::*;

  localparam int unsigned VPN_BITS  = UPPER_INDEX_BITS + LOWER_INDEX_BITS;
  localparam int unsigned PPN_BITS  = (PHYS_PAGES > 1) ? $clog2(PHYS_PAGES) : 1;
  localparam int unsigned FREE_BITS = $clog2(PHYS_PAGES + 1);
  localparam int unsigned FULL_PA   = PPN_BITS + OFFSET_BITS;
  localparam int unsigned EXT_BITS  = VA_BITS + OFFSET_BITS + VPN_BITS;

  dpt_state_e             state_q, state_d;
  logic [EXT_BITS-1:0]    va_ext;
  logic [VPN_BITS-1:0]    in_vpn;
  logic [OFFSET_BITS-1:0] off_q;
  logic                   accept, lookup_go;
  logic                   tlb_hit, tlb_wr, tbl_busy, tbl_valid, tbl_wr;
  logic                   alloc_full;
  logic [PPN_BITS-1:0]    tlb_page, tbl_page, alloc_page, page;
  dpt_flags_t             flags, flags_q;
  logic [FULL_PA-1:0]     pa_full;
  logic [FULL_PA+PA_BITS-1:0] pa_ext;
  logic [PA_BITS-1:0]     pa, pa_q;
  logic [CNT_BITS-1:0]    hit_cnt_q, hit_cnt_d, query_cnt_q, query_cnt_d;
  logic                   out_valid_q, out_valid_d;

  // split the incoming address; bits past the input read as zero
  assign va_ext = {{(OFFSET_BITS + VPN_BITS){1'b0}}, s_axis_tdata[VA_BITS-1:0]};
  assign in_vpn = va_ext[OFFSET_BITS +: VPN_BITS];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign lookup_go     = (state_q == ST_LOOKUP) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      off_q <= va_ext[OFFSET_BITS-1:0];
    end
  end

  dpt_tlb #(
    .VPN_BITS       (VPN_BITS),
    .TLB_INDEX_BITS (TLB_INDEX_BITS),
    .PPN_BITS       (PPN_BITS)
  ) u_tlb (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_vpn_i  (in_vpn),
    .wr_en_i   (tlb_wr),
    .wr_page_i (page),
    .hit_o     (tlb_hit),
    .page_o    (tlb_page)
  );

  dpt_table #(
    .VPN_BITS  (VPN_BITS),
    .PPN_BITS  (PPN_BITS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_vpn_i  (in_vpn),
    .wr_en_i   (tbl_wr),
    .wr_page_i (alloc_page),
    .busy_o    (tbl_busy),
    .valid_o   (tbl_valid),
    .page_o    (tbl_page)
  );

  dpt_alloc #(
    .PHYS_PAGES (PHYS_PAGES),
    .PPN_BITS   (PPN_BITS),
    .FREE_BITS  (FREE_BITS)
  ) u_alloc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (tbl_wr),
    .page_o (alloc_page),
    .full_o (alloc_full)
  );

  // translation decision
  always_comb begin
    flags.tlb_hit      = tlb_hit;
    flags.newly_mapped = !tlb_hit && !tbl_valid && !alloc_full;
    flags.out_of_pages = !tlb_hit && !tbl_valid && alloc_full;
    if (tlb_hit) begin
      page = tlb_page;
    end else if (tbl_valid) begin
      page = tbl_page;
    end else begin
      page = alloc_page;
    end
  end

  assign tbl_wr  = lookup_go && flags.newly_mapped;
  assign tlb_wr  = lookup_go && !tlb_hit && !flags.out_of_pages;
  assign pa_full = {page, off_q};
  assign pa_ext  = {{PA_BITS{1'b0}}, pa_full};
  assign pa      = flags.out_of_pages ? '0 : pa_ext[PA_BITS-1:0];

  // counters and output register control
  always_comb begin
    hit_cnt_d   = hit_cnt_q;
    query_cnt_d = query_cnt_q;
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (lookup_go) begin
      query_cnt_d = query_cnt_q + 1'b1;
      if (tlb_hit) begin
        hit_cnt_d = hit_cnt_q + 1'b1;
      end
      out_valid_d = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (!tbl_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (lookup_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      hit_cnt_q   <= '0;
      query_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hit_cnt_q   <= hit_cnt_d;
      query_cnt_q <= query_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (lookup_go) begin
      pa_q    <= pa;
      flags_q <= flags;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(8 * OUT_BYTES - OUT_FIELD){1'b0}}, query_cnt_q, hit_cnt_q, pa_q};
  assign m_axis_tuser  = flags_q;

endmodule

/* rtl/dpt_tlb.sv */
// direct-mapped tlb: tag/page memory with valid bits in flops
module dpt_tlb #(
  parameter int unsigned VPN_BITS       = 10,
  parameter int unsigned TLB_INDEX_BITS = 4,
  parameter int unsigned PPN_BITS       = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [VPN_BITS-1:0]  rd_vpn_i,
  input  logic                 wr_en_i,
  input  logic [PPN_BITS-1:0]  wr_page_i,
  output logic                 hit_o,
  output logic [PPN_BITS-1:0]  page_o
);
  import dpt_pkg::*;

  localparam int unsigned TLB_DEPTH = 1 << TLB_INDEX_BITS;
  localparam int unsigned ENTRY_W   = VPN_BITS + PPN_BITS;

  logic [ENTRY_W-1:0]             mem [TLB_DEPTH];
  logic [ENTRY_W-1:0]             rd_q;
  logic [VPN_BITS-1:0]            vpn_q;
  logic [TLB_DEPTH-1:0]           valid_q, valid_d;
  logic [TLB_INDEX_BITS+VPN_BITS-1:0] rd_ext, cur_ext;
  logic [TLB_INDEX_BITS-1:0]      rd_slot, cur_slot;

  // slot is the low page-number bits, zero extended for narrow page numbers
  assign rd_ext   = {{TLB_INDEX_BITS{1'b0}}, rd_vpn_i};
  assign cur_ext  = {{TLB_INDEX_BITS{1'b0}}, vpn_q};
  assign rd_slot  = rd_ext[TLB_INDEX_BITS-1:0];
  assign cur_slot = cur_ext[TLB_INDEX_BITS-1:0];

  // memory read and write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q  <= mem[rd_slot];
      vpn_q <= rd_vpn_i;
    end
    if (wr_en_i) begin
      mem[cur_slot] <= {vpn_q, wr_page_i};
    end
  end

  // valid bits
  always_comb begin
    valid_d = valid_q;
    if (wr_en_i) begin
      valid_d[cur_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // tag compare
  assign hit_o  = valid_q[cur_slot] && (rd_q[ENTRY_W-1:PPN_BITS] == vpn_q);
  assign page_o = rd_q[PPN_BITS-1:0];

endmodule

/* rtl/dpt_table.sv */
// flat page table memory with a clearing pass after reset
module dpt_table #(
  parameter int unsigned VPN_BITS  = 10,
  parameter int unsigned PPN_BITS  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [VPN_BITS-1:0]  rd_vpn_i,
  input  logic                 wr_en_i,
  input  logic [PPN_BITS-1:0]  wr_page_i,
  output logic                 busy_o,
  output logic                 valid_o,
  output logic [PPN_BITS-1:0]  page_o
);
  import dpt_pkg::*;

  localparam int unsigned DEPTH   = 1 << VPN_BITS;
  localparam int unsigned ENTRY_W = PPN_BITS + 1;

  logic [ENTRY_W-1:0]  mem [DEPTH];
  logic [ENTRY_W-1:0]  rd_q;
  logic [VPN_BITS-1:0] vpn_q;
  logic [VPN_BITS-1:0] clr_q, clr_d;
  logic                busy_q, busy_d;

  // memory port: clear sweep takes priority
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q  <= mem[rd_vpn_i];
      vpn_q <= rd_vpn_i;
    end
    if (busy_q) begin
      mem[clr_q] <= '0;
    end else if (wr_en_i) begin
      mem[vpn_q] <= {1'b1, wr_page_i};
    end
  end

  // clear sweep counter
  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_d = clr_q + 1'b1;
      if (clr_q == {VPN_BITS{1'b1}}) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o  = busy_q;
  assign valid_o = rd_q[PPN_BITS];
  assign page_o  = rd_q[PPN_BITS-1:0];

endmodule

/* rtl/dpt_alloc.sv */
// physical page allocator; pages are never freed, so the lowest free page is a count
module dpt_alloc #(
  parameter int unsigned PHYS_PAGES = 256,
  parameter int unsigned PPN_BITS   = 8,
  parameter int unsigned FREE_BITS  = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  output logic [PPN_BITS-1:0]  page_o,
  output logic                 full_o
);
  import dpt_pkg::*;

  logic [FREE_BITS-1:0] next_q, next_d;

  // next free page
  always_comb begin
    next_d = next_q;
    if (take_i) begin
      next_d = next_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q <= '0;
    end else begin
      next_q <= next_d;
    end
  end

  assign full_o = (next_q == FREE_BITS'(PHYS_PAGES));
  assign page_o = next_q[PPN_BITS-1:0];

endmodule

/* bench/demand_paged_translation_unit_test.sv */
// testbench for the demand paged translation unit: predicted translations checked per transaction
module demand_paged_translation_unit_test;

  import dpt_pkg::*;

  localparam int unsigned OFFSET_BITS      = 12;
  localparam int unsigned UPPER_INDEX_BITS = 5;
  localparam int unsigned LOWER_INDEX_BITS = 5;
  localparam int unsigned TLB_INDEX_BITS   = 4;
  localparam int unsigned PHYS_PAGES       = 256;

  localparam int unsigned VPN_BITS    = UPPER_INDEX_BITS + LOWER_INDEX_BITS;
  localparam int unsigned TABLE_DEPTH = 1 << VPN_BITS;
  localparam int unsigned TLB_DEPTH   = 1 << TLB_INDEX_BITS;
  localparam int unsigned PPN_BITS    = $clog2(PHYS_PAGES);

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1000;
  localparam int DRAIN_CYCLES = 10;
  // clear sweep plus every item at its longest gap and stall, taken many times over
  localparam int CYCLE_LIMIT  = 400000;

  // one predicted translation
  typedef struct packed {
    logic [PA_BITS-1:0]  phys_addr;
    logic                tlb_hit;
    logic                newly_mapped;
    logic                out_of_pages;
    logic [CNT_BITS-1:0] hit_total;
    logic [CNT_BITS-1:0] query_total;
  } xlate_result_t;

  // translation predictor and queue of pending translations
  class translation_scoreboard;
    logic                      tlb_valid [TLB_DEPTH];
    logic [VPN_BITS-1:0]       tlb_tag   [TLB_DEPTH];
    logic [PPN_BITS-1:0]       tlb_page  [TLB_DEPTH];
    logic                      table_valid [TABLE_DEPTH];
    logic [PPN_BITS-1:0]       table_page  [TABLE_DEPTH];
    logic                      page_used   [PHYS_PAGES];
    logic [CNT_BITS-1:0]       hit_count;
    logic [CNT_BITS-1:0]       query_count;
    xlate_result_t             expected_xlate [$];
    int                        errors;

    function new();
      foreach (tlb_valid[i]) tlb_valid[i] = 1'b0;
      foreach (table_valid[i]) table_valid[i] = 1'b0;
      foreach (page_used[i]) page_used[i] = 1'b0;
      hit_count   = '0;
      query_count = '0;
      errors      = 0;
    endfunction

    // predict the translation of one accepted virtual address
    function void note_address(logic [VA_BITS-1:0] virt_addr);
      logic [OFFSET_BITS-1:0]    offset;
      logic [VPN_BITS-1:0]       vpn;
      logic [TLB_INDEX_BITS-1:0] slot;
      logic [PPN_BITS-1:0]       page;
      logic                      found;
      xlate_result_t             res;
      offset = virt_addr[OFFSET_BITS-1:0];
      vpn    = virt_addr[OFFSET_BITS +: VPN_BITS];
      slot   = vpn[TLB_INDEX_BITS-1:0];
      page   = '0;
      res    = '0;
      query_count = query_count + 1;
      if (tlb_valid[slot] && tlb_tag[slot] == vpn) begin
        res.tlb_hit = 1'b1;
        hit_count   = hit_count + 1;
        page        = tlb_page[slot];
      end else begin
        if (table_valid[vpn]) begin
          page = table_page[vpn];
        end else begin
          // lowest free physical page
          found = 1'b0;
          for (int p = 0; p < PHYS_PAGES; p++) begin
            if (!found && !page_used[p]) begin
              found = 1'b1;
              page  = p[PPN_BITS-1:0];
            end
          end
          if (found) begin
            page_used[page]  = 1'b1;
            table_valid[vpn] = 1'b1;
            table_page[vpn]  = page;
            res.newly_mapped = 1'b1;
          end else begin
            res.out_of_pages = 1'b1;
          end
        end
        // refill the slot unless allocation failed
        if (!res.out_of_pages) begin
          tlb_valid[slot] = 1'b1;
          tlb_tag[slot]   = vpn;
          tlb_page[slot]  = page;
        end
      end
      if (!res.out_of_pages) begin
        res.phys_addr = PA_BITS'({page, offset});
      end
      res.hit_total   = hit_count;
      res.query_total = query_count;
      expected_xlate.push_back(res);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    // compare one result transaction with the oldest prediction
    function void check_translation(logic [8*OUT_BYTES-1:0] data, logic [2:0] user);
      xlate_result_t want;
      dpt_flags_t    flags;
      if (expected_xlate.size() == 0) begin
        $error("result transaction with no translation pending");
        errors++;
        return;
      end
      want  = expected_xlate.pop_front();
      flags = user;
      compare_field("phys_addr", want.phys_addr, data[PA_BITS-1:0]);
      compare_field("hit_total", want.hit_total, data[PA_BITS +: CNT_BITS]);
      compare_field("query_total", want.query_total, data[PA_BITS+CNT_BITS +: CNT_BITS]);
      compare_field("tlb_hit", want.tlb_hit, flags.tlb_hit);
      compare_field("newly_mapped", want.newly_mapped, flags.newly_mapped);
      compare_field("out_of_pages", want.out_of_pages, flags.out_of_pages);
    endfunction

    function int pending();
      return expected_xlate.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [8*IN_BYTES-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [8*OUT_BYTES-1:0] m_axis_tdata;
  logic [2:0]             m_axis_tuser;

  translation_scoreboard board = new();
  int                    cycle_count = 0;
  logic [VPN_BITS-1:0]   recent_vpn [$];

  demand_paged_translation_unit #(
    .OFFSET_BITS     (OFFSET_BITS),
    .UPPER_INDEX_BITS(UPPER_INDEX_BITS),
    .LOWER_INDEX_BITS(LOWER_INDEX_BITS),
    .TLB_INDEX_BITS  (TLB_INDEX_BITS),
    .PHYS_PAGES      (PHYS_PAGES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // clock
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result transaction monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_translation(m_axis_tdata, m_axis_tuser);
    end
  end

  // receiver stall pattern: free running, random, or periodic windows
  initial begin
    int mode;
    int span;
    int period;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode   = $urandom_range(0, 2);
      span   = $urandom_range(16, 200);
      period = $urandom_range(2, 5);
      for (int c = 0; c < span; c++) begin
        @(negedge clk_i);
        case (mode)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= $urandom_range(0, 1);
          end
          default: begin
            m_axis_tready <= (c % period) == 0;
          end
        endcase
      end
    end
  end

  // offer one address and wait until it is accepted
  task automatic send_address(input logic [VA_BITS-1:0] virt_addr);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(8*IN_BYTES-VA_BITS){1'b0}}, virt_addr};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_address(virt_addr);
    recent_vpn.push_back(virt_addr[OFFSET_BITS +: VPN_BITS]);
    if (recent_vpn.size() > 8) void'(recent_vpn.pop_front());
  endtask

  // drop valid for a number of cycles
  task automatic hold_off(input int cycles);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // random address: random pages, recent pages, or slot conflicts
  function automatic logic [VA_BITS-1:0] random_address();
    logic [VPN_BITS-1:0]    vpn;
    logic [OFFSET_BITS-1:0] offset;
    int                     pick;
    pick   = $urandom_range(0, 99);
    offset = $urandom_range(0, (1 << OFFSET_BITS) - 1);
    vpn    = $urandom_range(0, TABLE_DEPTH - 1);
    if (recent_vpn.size() != 0 && pick >= 45) begin
      if (pick < 80) begin
        vpn = recent_vpn[$urandom_range(0, recent_vpn.size() - 1)];
      end else begin
        vpn[TLB_INDEX_BITS-1:0] =
          recent_vpn[$urandom_range(0, recent_vpn.size() - 1)][TLB_INDEX_BITS-1:0];
      end
    end
    return {vpn, offset};
  endfunction

  // directed addresses: extremes, hits, conflicts, refills from the table
  logic [VA_BITS-1:0] directed_addr [] = '{
    22'h000000, 22'h000FFF, 22'h3FFFFF, 22'h3FF000, 22'h010ABC,
    22'h000123, 22'h010000, 22'h200800, 22'h1FF7FF, 22'h155555,
    22'h2AAAAA, 22'h2AAAAA, 22'h001001, 22'h002002, 22'h3F0FFF,
    22'h000000, 22'h3FFFFF, 22'h20F000, 22'h00F000, 22'h1FFFFF
  };

  // main sequence
  initial begin
    int burst;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, back to back with a few gaps
    foreach (directed_addr[i]) begin
      send_address(directed_addr[i]);
      if (i % 5 == 4) hold_off($urandom_range(1, 3));
    end

    // random part in bursts
    burst = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst == 0) begin
        hold_off($urandom_range(1, 6));
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      end
      send_address(random_address());
      burst--;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // drain
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
